// ----- rtl/slt_pkg.sv -----
// ----------------------------------------------------------------------------
// slt_pkg: shared definitions for the script lexer tokenizer
// Lexer modes, token kinds, character codes, queue sizing and character
// class helpers.
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int OFFSET_BITS_DEF = 24;
    localparam int LENGTH_BITS_DEF = 16;
    localparam int LINE_BITS       = 24;
    localparam int KIND_BITS       = 3;
    localparam int Q_DEPTH         = 8;
    localparam int Q_PTR_BITS      = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS      = $clog2(Q_DEPTH + 1);
    localparam int MAX_PUSH        = 4;

    typedef enum logic [3:0] {
        M_IDLE  = 4'd0,
        M_WORD  = 4'd1,
        M_ZERO  = 4'd2,
        M_INT   = 4'd3,
        M_ZX    = 4'd4,
        M_HEX   = 4'd5,
        M_FRAC  = 4'd6,
        M_EXP1  = 4'd7,
        M_EXP2  = 4'd8,
        M_EXPD  = 4'd9,
        M_OP    = 4'd10,
        M_SLASH = 4'd11,
        M_STAR  = 4'd12,
        M_QUOTE = 4'd13
    } mode_t;

    localparam logic [2:0] K_WORD  = 3'd0;
    localparam logic [2:0] K_INT   = 3'd1;
    localparam logic [2:0] K_FLOAT = 3'd2;
    localparam logic [2:0] K_HEX   = 3'd3;
    localparam logic [2:0] K_STR   = 3'd4;
    localparam logic [2:0] K_CHAR  = 3'd5;
    localparam logic [2:0] K_OP    = 3'd6;
    localparam logic [2:0] K_OPEN  = 3'd7;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UE    = 8'h45;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LE    = 8'h65;
    localparam logic [7:0] CH_LF_F  = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DOLLAR = 8'h24;

    // Standalone punctuation: ! ? : { } ( ) [ ] ; @ ,
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    // Operators that chain: + - * / = > < % ~ & | ^
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_CARET = 8'h5E;

    typedef struct packed {
        logic idle;
        logic off_zero;
    } lex_status_t;

    function automatic logic is_ws(logic [7:0] c);
        return (c == CH_CR) || (c == CH_LF) || (c == CH_TAB) || (c == CH_SPACE);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ)) ||
               (c == CH_UNDER) || (c == CH_DOLLAR);
    endfunction

    function automatic logic is_hex(logic [7:0] c);
        return is_digit(c) || ((c >= CH_LA) && (c <= CH_LF_F)) ||
               ((c >= CH_UA) && (c <= CH_UF));
    endfunction

    function automatic logic is_alone(logic [7:0] c);
        return (c == CH_BANG) || (c == CH_QMARK) || (c == CH_COLON) ||
               (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_LPAREN) ||
               (c == CH_RPAREN) || (c == CH_LBRACK) || (c == CH_RBRACK) ||
               (c == CH_SEMI) || (c == CH_AT) || (c == CH_COMMA);
    endfunction

    function automatic logic is_chain_op(logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
               (c == CH_SLASH) || (c == CH_EQ) || (c == CH_GT) || (c == CH_LT) ||
               (c == CH_PCT) || (c == CH_TILDE) || (c == CH_AMP) ||
               (c == CH_PIPE) || (c == CH_CARET);
    endfunction

endpackage

// ----- rtl/slt_fifo.sv -----
// ----------------------------------------------------------------------------
// slt_fifo: token record queue
// Small register queue that takes up to four records per cycle and hands
// out one record per cycle while it is popped.
// ----------------------------------------------------------------------------
module slt_fifo #(
    parameter int W = 68
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic [2:0]                              push_cnt,
    input  logic [slt_pkg::MAX_PUSH-1:0][W-1:0]     push_data,
    input  logic                                    pop,
    output logic                                    out_valid,
    output logic [W-1:0]                            out_data,
    output logic [slt_pkg::Q_CNT_BITS-1:0]          level
);

    logic [W-1:0]                      mem [slt_pkg::Q_DEPTH];
    logic [slt_pkg::Q_PTR_BITS-1:0]    wr_ptr_reg;
    logic [slt_pkg::Q_PTR_BITS-1:0]    wr_ptr_next;
    logic [slt_pkg::Q_PTR_BITS-1:0]    rd_ptr_reg;
    logic [slt_pkg::Q_PTR_BITS-1:0]    rd_ptr_next;
    logic [slt_pkg::Q_CNT_BITS-1:0]    count_reg;
    logic [slt_pkg::Q_CNT_BITS-1:0]    count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + slt_pkg::Q_PTR_BITS'(push_cnt);
        rd_ptr_next = rd_ptr_reg + slt_pkg::Q_PTR_BITS'(pop);
        count_next  = count_reg + slt_pkg::Q_CNT_BITS'(push_cnt)
                      - slt_pkg::Q_CNT_BITS'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < slt_pkg::MAX_PUSH; i++)
        begin
            if (3'(i) < push_cnt)
            begin
                mem[wr_ptr_reg + slt_pkg::Q_PTR_BITS'(i)] <= push_data[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign level     = count_reg;

endmodule

// ----- rtl/slt_core.sv -----
// ----------------------------------------------------------------------------
// slt_core: lexer state and per-byte step logic
// Holds the lexer state and, for one registered byte, works out the new
// state and up to four token records combinationally.
// ----------------------------------------------------------------------------
module slt_core #(
    parameter int OB = slt_pkg::OFFSET_BITS_DEF,
    parameter int LB = slt_pkg::LENGTH_BITS_DEF,
    parameter int W  = 1 + slt_pkg::KIND_BITS + OB + LB + slt_pkg::LINE_BITS
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    proc,
    input  logic [7:0]                              byte_in,
    input  logic                                    eot_in,
    output logic [2:0]                              push_cnt,
    output logic [slt_pkg::MAX_PUSH-1:0][W-1:0]     push_rec,
    output slt_pkg::lex_status_t                    status
);

    localparam int NSLOT = 7;
    localparam logic [OB-1:0] OFF_MAX = {OB{1'b1}};
    localparam logic [LB-1:0] LEN_MAX = {LB{1'b1}};
    localparam logic [LB-1:0] LEN_ONE = LB'(1);
    localparam logic [slt_pkg::LINE_BITS-1:0] LINE_MAX = {slt_pkg::LINE_BITS{1'b1}};

    typedef struct packed {
        slt_pkg::mode_t  mode;
        logic            lc;
        logic            blk;
        logic            bstar;
        logic [OB-1:0]   ts;
        logic [LB-1:0]   tl;
        logic [7:0]      qc;
        logic [7:0]      la0;
        logic [7:0]      la1;
    } lst_t;

    typedef struct packed {
        lst_t            st;
        logic            ev;
        logic [2:0]      k;
        logic [OB-1:0]   es;
        logic [LB-1:0]   el;
        logic [1:0]      rel;
    } fres_t;

    function automatic logic [LB-1:0] grow(logic [LB-1:0] tl, logic [1:0] n);
        logic [LB+1:0] sum;
        sum = {2'b00, tl} + (LB+2)'(n);
        return (sum[LB+1:LB] != 2'b00) ? LEN_MAX : sum[LB-1:0];
    endfunction

    function automatic logic [OB-1:0] back(logic [OB-1:0] off, logic [1:0] n);
        return (off >= OB'(n)) ? (off - OB'(n)) : '0;
    endfunction

    function automatic fres_t feed(lst_t s, logic [7:0] c, logic [OB-1:0] off);
        fres_t r;
        logic  go;
        logic  closed;
        r     = '0;
        r.st  = s;
        r.k   = slt_pkg::K_WORD;
        r.es  = s.ts;
        r.el  = s.tl;
        go    = 1'b0;
        unique case (s.mode)
            slt_pkg::M_WORD:
            begin
                if (slt_pkg::is_letter(c) || slt_pkg::is_digit(c))
                    r.st.tl = grow(s.tl, 2'd1);
                else
                begin
                    r.ev = 1'b1;
                    r.k  = slt_pkg::K_WORD;
                    go   = 1'b1;
                end
            end
            slt_pkg::M_ZERO, slt_pkg::M_INT:
            begin
                if (s.mode == slt_pkg::M_ZERO && (c == slt_pkg::CH_LX || c == slt_pkg::CH_UX))
                begin
                    r.st.la0  = c;
                    r.st.mode = slt_pkg::M_ZX;
                end
                else if (slt_pkg::is_digit(c))
                begin
                    r.st.tl   = grow(s.tl, 2'd1);
                    r.st.mode = slt_pkg::M_INT;
                end
                else if (c == slt_pkg::CH_DOT)
                begin
                    r.st.tl   = grow(s.tl, 2'd1);
                    r.st.mode = slt_pkg::M_FRAC;
                end
                else
                begin
                    r.ev = 1'b1;
                    r.k  = slt_pkg::K_INT;
                    go   = 1'b1;
                end
            end
            slt_pkg::M_ZX:
            begin
                if (slt_pkg::is_hex(c))
                begin
                    r.st.tl   = grow(s.tl, 2'd2);
                    r.st.mode = slt_pkg::M_HEX;
                end
                else
                begin
                    r.ev      = 1'b1;
                    r.k       = slt_pkg::K_INT;
                    r.rel     = 2'd1;
                    r.st.mode = slt_pkg::M_IDLE;
                end
            end
            slt_pkg::M_HEX:
            begin
                if (slt_pkg::is_hex(c))
                    r.st.tl = grow(s.tl, 2'd1);
                else
                begin
                    r.ev = 1'b1;
                    r.k  = slt_pkg::K_HEX;
                    go   = 1'b1;
                end
            end
            slt_pkg::M_FRAC, slt_pkg::M_EXPD:
            begin
                if (slt_pkg::is_digit(c))
                    r.st.tl = grow(s.tl, 2'd1);
                else if (c == slt_pkg::CH_LF_F)
                begin
                    // A trailing f is part of the float and closes it.
                    r.st.tl   = grow(s.tl, 2'd1);
                    r.ev      = 1'b1;
                    r.k       = slt_pkg::K_FLOAT;
                    r.el      = r.st.tl;
                    r.st.mode = slt_pkg::M_IDLE;
                end
                else if (s.mode == slt_pkg::M_FRAC &&
                         (c == slt_pkg::CH_LE || c == slt_pkg::CH_UE))
                begin
                    r.st.la0  = c;
                    r.st.mode = slt_pkg::M_EXP1;
                end
                else
                begin
                    r.ev = 1'b1;
                    r.k  = slt_pkg::K_FLOAT;
                    go   = 1'b1;
                end
            end
            slt_pkg::M_EXP1:
            begin
                if (slt_pkg::is_digit(c))
                begin
                    r.st.tl   = grow(s.tl, 2'd2);
                    r.st.mode = slt_pkg::M_EXPD;
                end
                else if (c == slt_pkg::CH_PLUS || c == slt_pkg::CH_MINUS)
                begin
                    r.st.la1  = c;
                    r.st.mode = slt_pkg::M_EXP2;
                end
                else
                begin
                    r.ev      = 1'b1;
                    r.k       = slt_pkg::K_FLOAT;
                    r.rel     = 2'd1;
                    r.st.mode = slt_pkg::M_IDLE;
                end
            end
            slt_pkg::M_EXP2:
            begin
                if (slt_pkg::is_digit(c))
                begin
                    r.st.tl   = grow(s.tl, 2'd3);
                    r.st.mode = slt_pkg::M_EXPD;
                end
                else
                begin
                    r.ev      = 1'b1;
                    r.k       = slt_pkg::K_FLOAT;
                    r.rel     = 2'd2;
                    r.st.mode = slt_pkg::M_IDLE;
                end
            end
            slt_pkg::M_OP:
            begin
                if (slt_pkg::is_chain_op(c))
                    r.st.tl = grow(s.tl, 2'd1);
                else
                begin
                    r.ev = 1'b1;
                    r.k  = slt_pkg::K_OP;
                    go   = 1'b1;
                end
            end
            slt_pkg::M_SLASH, slt_pkg::M_STAR:
            begin
                if (s.mode == slt_pkg::M_SLASH && c == slt_pkg::CH_SLASH)
                begin
                    r.st.lc   = 1'b1;
                    r.st.mode = slt_pkg::M_IDLE;
                end
                else if (s.mode == slt_pkg::M_SLASH && c == slt_pkg::CH_STAR)
                begin
                    r.st.blk   = 1'b1;
                    r.st.bstar = 1'b0;
                    r.st.mode  = slt_pkg::M_IDLE;
                end
                else if (s.mode == slt_pkg::M_STAR && c == slt_pkg::CH_SLASH)
                    r.st.mode = slt_pkg::M_IDLE;
                else
                begin
                    // The held byte becomes a one-byte operator run.
                    r.st.ts   = back(off, 2'd1);
                    r.st.tl   = LEN_ONE;
                    r.st.mode = slt_pkg::M_OP;
                    if (slt_pkg::is_chain_op(c))
                        r.st.tl = grow(LEN_ONE, 2'd1);
                    else
                    begin
                        r.ev = 1'b1;
                        r.k  = slt_pkg::K_OP;
                        r.es = r.st.ts;
                        r.el = LEN_ONE;
                        go   = 1'b1;
                    end
                end
            end
            slt_pkg::M_QUOTE:
            begin
                if (c == s.qc)
                begin
                    r.ev      = 1'b1;
                    r.k       = (s.qc == slt_pkg::CH_DQUOTE) ? slt_pkg::K_STR : slt_pkg::K_CHAR;
                    r.st.mode = slt_pkg::M_IDLE;
                end
                else
                    r.st.tl = grow(s.tl, 2'd1);
            end
            default:
                go = 1'b1;
        endcase

        if (go)
        begin
            r.st.mode = slt_pkg::M_IDLE;
            if (r.st.lc)
            begin
                if (c == slt_pkg::CH_LF || c == slt_pkg::CH_CR)
                    r.st.lc = 1'b0;
            end
            else if (r.st.blk)
            begin
                closed     = r.st.bstar && (c == slt_pkg::CH_SLASH);
                r.st.bstar = 1'b0;
                if (closed)
                    r.st.blk = 1'b0;
                else if (c == slt_pkg::CH_STAR)
                    r.st.bstar = 1'b1;
            end
            else if (slt_pkg::is_ws(c))
                r.st.mode = slt_pkg::M_IDLE;
            else if (c == slt_pkg::CH_SLASH)
                r.st.mode = slt_pkg::M_SLASH;
            else if (c == slt_pkg::CH_STAR)
                r.st.mode = slt_pkg::M_STAR;
            else if (c == slt_pkg::CH_DQUOTE || c == slt_pkg::CH_SQUOTE)
            begin
                r.st.qc   = c;
                r.st.ts   = (off == OFF_MAX) ? OFF_MAX : off + OB'(1);
                r.st.tl   = '0;
                r.st.mode = slt_pkg::M_QUOTE;
            end
            else if (slt_pkg::is_letter(c) || slt_pkg::is_digit(c) ||
                     slt_pkg::is_chain_op(c) || slt_pkg::is_alone(c))
            begin
                r.st.ts = off;
                r.st.tl = LEN_ONE;
                if (slt_pkg::is_letter(c))
                    r.st.mode = slt_pkg::M_WORD;
                else if (c == slt_pkg::CH_ZERO)
                    r.st.mode = slt_pkg::M_ZERO;
                else if (slt_pkg::is_digit(c))
                    r.st.mode = slt_pkg::M_INT;
                else
                    r.st.mode = slt_pkg::M_OP;
            end
        end
        return r;
    endfunction

    function automatic logic [W-1:0] mk(logic [2:0] k, logic [OB-1:0] s, logic [LB-1:0] l,
                                        logic [slt_pkg::LINE_BITS-1:0] ln);
        return {1'b0, k, s, l, ln};
    endfunction

    lst_t                            st_reg;
    lst_t                            st_next;
    logic [OB-1:0]                   off_reg;
    logic [OB-1:0]                   off_next;
    logic [slt_pkg::LINE_BITS-1:0]   line_reg;
    logic [slt_pkg::LINE_BITS-1:0]   line_next;

    fres_t                           r0;
    fres_t                           r1;
    fres_t                           r2;
    fres_t                           rr;
    fres_t                           r3;
    lst_t                            fs;
    logic                            have_rel;
    logic [slt_pkg::LINE_BITS-1:0]   line_nx;
    logic [NSLOT-1:0]                slot_v;
    logic [NSLOT-1:0][W-1:0]         slot_rec;
    logic [2:0]                      cnt;
    logic [2:0]                      pcnt;
    logic [slt_pkg::MAX_PUSH-1:0][W-1:0] recs;

    always_comb
    begin
        r0 = feed(st_reg, byte_in, off_reg);
        r1 = feed(r0.st, st_reg.la0,
                  (r0.rel == 2'd2) ? back(off_reg, 2'd2) : back(off_reg, 2'd1));
        r2 = feed(r1.st, st_reg.la1, back(off_reg, 2'd1));
        rr = (r0.rel == 2'd2) ? r2 : r1;
        r3 = feed(rr.st, byte_in, off_reg);
        have_rel = (r0.rel != 2'd0);
        fs = have_rel ? r3.st : r0.st;

        line_nx = (byte_in == slt_pkg::CH_LF && line_reg != LINE_MAX) ?
                  line_reg + slt_pkg::LINE_BITS'(1) : line_reg;

        slot_v      = '0;
        slot_v[0]   = r0.ev;
        slot_v[1]   = have_rel && r1.ev;
        slot_v[2]   = (r0.rel == 2'd2) && r2.ev;
        slot_v[3]   = have_rel && r3.ev;
        slot_rec[0] = mk(r0.k, r0.es, r0.el, line_reg);
        slot_rec[1] = mk(r1.k, r1.es, r1.el, line_reg);
        slot_rec[2] = mk(r2.k, r2.es, r2.el, line_reg);
        slot_rec[3] = mk(r3.k, r3.es, r3.el, line_reg);
        slot_rec[4] = mk(slt_pkg::K_WORD, fs.ts, fs.tl, line_nx);
        slot_rec[5] = mk(slt_pkg::K_WORD, off_reg, LEN_ONE, line_nx);
        slot_rec[6] = mk(slt_pkg::K_OP, off_reg, LEN_ONE, line_nx);

        // End of text flushes the pending token and any held bytes.
        if (eot_in)
        begin
            unique case (fs.mode)
                slt_pkg::M_WORD:
                    slot_v[4] = 1'b1;
                slt_pkg::M_ZERO, slt_pkg::M_INT:
                begin
                    slot_v[4] = 1'b1;
                    slot_rec[4] = mk(slt_pkg::K_INT, fs.ts, fs.tl, line_nx);
                end
                slt_pkg::M_HEX:
                begin
                    slot_v[4] = 1'b1;
                    slot_rec[4] = mk(slt_pkg::K_HEX, fs.ts, fs.tl, line_nx);
                end
                slt_pkg::M_FRAC, slt_pkg::M_EXPD:
                begin
                    slot_v[4] = 1'b1;
                    slot_rec[4] = mk(slt_pkg::K_FLOAT, fs.ts, fs.tl, line_nx);
                end
                slt_pkg::M_OP:
                begin
                    slot_v[4] = 1'b1;
                    slot_rec[4] = mk(slt_pkg::K_OP, fs.ts, fs.tl, line_nx);
                end
                slt_pkg::M_SLASH, slt_pkg::M_STAR:
                    slot_v[6] = 1'b1;
                slt_pkg::M_ZX:
                begin
                    slot_v[4] = 1'b1;
                    slot_v[5] = 1'b1;
                    slot_rec[4] = mk(slt_pkg::K_INT, fs.ts, fs.tl, line_nx);
                end
                slt_pkg::M_EXP1:
                begin
                    slot_v[4] = 1'b1;
                    slot_v[5] = 1'b1;
                    slot_rec[4] = mk(slt_pkg::K_FLOAT, fs.ts, fs.tl, line_nx);
                end
                slt_pkg::M_EXP2:
                begin
                    slot_v[4] = 1'b1;
                    slot_v[5] = 1'b1;
                    slot_v[6] = 1'b1;
                    slot_rec[4] = mk(slt_pkg::K_FLOAT, fs.ts, fs.tl, line_nx);
                    slot_rec[5] = mk(slt_pkg::K_WORD, back(off_reg, 2'd1), LEN_ONE, line_nx);
                end
                slt_pkg::M_QUOTE:
                begin
                    slot_v[4] = 1'b1;
                    slot_rec[4] = mk(slt_pkg::K_OPEN, fs.ts, fs.tl, line_nx);
                end
                default:
                    slot_v[4] = 1'b0;
            endcase
        end

        cnt  = '0;
        recs = '0;
        for (int i = 0; i < NSLOT; i++)
        begin
            if (slot_v[i])
            begin
                if (cnt < 3'(slt_pkg::MAX_PUSH))
                    recs[cnt[1:0]] = slot_rec[i];
                cnt = cnt + 3'd1;
            end
        end
        pcnt = (cnt > 3'(slt_pkg::MAX_PUSH)) ? 3'(slt_pkg::MAX_PUSH) : cnt;
        if (pcnt != 3'd0)
            recs[2'(pcnt - 3'd1)][W-1] = 1'b1;

        st_next   = st_reg;
        off_next  = off_reg;
        line_next = line_reg;
        if (proc)
        begin
            if (eot_in)
            begin
                st_next      = '0;
                st_next.mode = slt_pkg::M_IDLE;
                off_next     = '0;
                line_next    = slt_pkg::LINE_BITS'(1);
            end
            else
            begin
                st_next   = fs;
                off_next  = (off_reg == OFF_MAX) ? OFF_MAX : off_reg + OB'(1);
                line_next = line_nx;
            end
        end
    end

    // An all-zero state word is the idle mode with no comment open.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= '0;
            off_reg     <= '0;
            line_reg    <= slt_pkg::LINE_BITS'(1);
        end
        else
        begin
            st_reg   <= st_next;
            off_reg  <= off_next;
            line_reg <= line_next;
        end
    end

    assign push_cnt        = proc ? pcnt : 3'd0;
    assign push_rec        = recs;
    assign status.idle     = (st_reg.mode == slt_pkg::M_IDLE) && !st_reg.lc && !st_reg.blk;
    assign status.off_zero = (off_reg == '0);

endmodule

// ----- rtl/script_lexer_tokenizer.sv -----
// ----------------------------------------------------------------------------
// script_lexer_tokenizer: streaming lexer for C-like source text
// Turns a byte stream into token records with kind, offset, length and line.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid / in_stall) carries one source byte per
// transaction, with end_of_text marking the final byte of a text. The output
// channel (out_valid / out_stall) carries one token record per transaction;
// last_of_run flags the final record caused by one input byte.
// An accepted byte is held in the input register while the lexer step runs
// on it; once the record queue has room, up to four records are written
// into that eight-entry record queue, and the first of them is offered on
// the output from the queue.
// Throughput is one byte per cycle; the input stalls only while the record
// queue holds more than four entries, which happens when the receiver stalls
// or when bytes produce records faster than one per cycle.
// Reset empties the queue and returns the lexer to idle at offset zero,
// line one. End of text flushes the pending token and returns to that state.
// A stalled output record holds steady until it is taken.
// ----------------------------------------------------------------------------
module script_lexer_tokenizer #(
    parameter int OFFSET_BITS = slt_pkg::OFFSET_BITS_DEF,
    parameter int LENGTH_BITS = slt_pkg::LENGTH_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       text_byte,
    input  logic                             end_of_text,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [2:0]                       kind,
    output logic [OFFSET_BITS-1:0]           start_offset,
    output logic [LENGTH_BITS-1:0]           lexeme_length,
    output logic [slt_pkg::LINE_BITS-1:0]    line_number,
    output logic                             last_of_run
);

    localparam int W = 1 + slt_pkg::KIND_BITS + OFFSET_BITS + LENGTH_BITS +
                       slt_pkg::LINE_BITS;

    logic                                  in_valid_reg;
    logic                                  in_valid_next;
    logic [7:0]                            byte_reg;
    logic                                  eot_reg;
    logic                                  proc;
    logic                                  pop;
    logic [2:0]                            push_cnt;
    logic [slt_pkg::MAX_PUSH-1:0][W-1:0]   push_rec;
    logic [W-1:0]                          q_data;
    logic [slt_pkg::Q_CNT_BITS-1:0]        level;
    slt_pkg::lex_status_t                  status;

    assign proc     = in_valid_reg &&
                      (level <= slt_pkg::Q_CNT_BITS'(slt_pkg::Q_DEPTH - slt_pkg::MAX_PUSH));
    assign in_stall = in_valid_reg && !proc;
    assign in_valid_next = in_stall ? in_valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= text_byte;
            eot_reg  <= end_of_text;
        end
    end

    slt_core #(
        .OB (OFFSET_BITS),
        .LB (LENGTH_BITS),
        .W  (W)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .proc     (proc),
        .byte_in  (byte_reg),
        .eot_in   (eot_reg),
        .push_cnt (push_cnt),
        .push_rec (push_rec),
        .status   (status)
    );

    slt_fifo #(
        .W (W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push_data (push_rec),
        .pop       (pop),
        .out_valid (out_valid),
        .out_data  (q_data),
        .level     (level)
    );

    assign pop           = out_valid && !out_stall;
    assign last_of_run   = q_data[W-1];
    assign kind          = q_data[W-2 -: slt_pkg::KIND_BITS];
    assign start_offset  = q_data[slt_pkg::LINE_BITS + LENGTH_BITS +: OFFSET_BITS];
    assign lexeme_length = q_data[slt_pkg::LINE_BITS +: LENGTH_BITS];
    assign line_number   = q_data[slt_pkg::LINE_BITS-1:0];

    // The queue must never be pushed past its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        level <= slt_pkg::Q_CNT_BITS'(slt_pkg::Q_DEPTH))
        else $error("record queue overflow");

    // A processed final byte leaves the lexer idle at offset zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (proc && eot_reg) |=> (status.idle && status.off_zero))
        else $error("lexer not back at start after end of text");

    // No records are written unless a byte is being processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        !proc |-> (push_cnt == 3'd0))
        else $error("records pushed without a byte");

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the script lexer tokenizer
// Random and directed source texts are fed one byte per transaction. A
// behavioral lexer predicts the token records, and a monitor compares every
// record taken from the block, field by field, in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam longint OFF_LIMIT  = 64'hFF_FFFF;
    localparam longint LEN_LIMIT  = 64'hFFFF;
    localparam longint LINE_LIMIT = 64'hFF_FFFF;
    localparam int     STALL_LIMIT = 5000;

    typedef struct {
        logic [7:0] b;
        logic       eot;
    } src_item_t;

    typedef struct {
        logic [2:0]  kind;
        logic [23:0] start;
        logic [15:0] len;
        logic [23:0] line;
        logic        last;
    } tok_rec_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  text_byte = 8'd0;
    logic        end_of_text = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  kind;
    logic [23:0] start_offset;
    logic [15:0] lexeme_length;
    logic [23:0] line_number;
    logic        last_of_run;

    script_lexer_tokenizer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .text_byte     (text_byte),
        .end_of_text   (end_of_text),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .start_offset  (start_offset),
        .lexeme_length (lexeme_length),
        .line_number   (line_number),
        .last_of_run   (last_of_run)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    src_item_t  pending_bytes[$];
    tok_rec_t   expected_tokens[$];
    logic [7:0] text_buf[$];
    int         bytes_taken = 0;
    int         bytes_offered = 0;
    int         mismatches = 0;
    int         send_idle_pct = 21;
    int         recv_idle_pct = 71;
    int         idle_cycles = 0;

    // Lexer shadow state.
    slt_pkg::mode_t lx_mode;
    bit         lx_block;
    bit         lx_linec;
    longint     lx_offset;
    longint     lx_start;
    longint     lx_len;
    longint     lx_line;
    logic [7:0] lx_quote;
    logic [7:0] lx_hold[2];
    int         lx_held;
    tok_rec_t   step_recs[4];
    int         step_cnt;

    function automatic bit cls_ws(logic [7:0] c);
        return c == slt_pkg::CH_CR || c == slt_pkg::CH_LF || c == slt_pkg::CH_TAB ||
               c == slt_pkg::CH_SPACE;
    endfunction

    function automatic bit cls_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit cls_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || c == "$";
    endfunction

    function automatic bit cls_hex(logic [7:0] c);
        return cls_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic bit in_str(string s, logic [7:0] c);
        for (int i = 0; i < s.len(); i++)
            if (s[i] == c)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit cls_op(logic [7:0] c);
        return in_str("+-*/=><%~!&|^?:{}()[];@,", c);
    endfunction

    function automatic bit cls_alone(logic [7:0] c);
        return in_str("!?:{}()[];@,", c);
    endfunction

    function automatic longint step_back(longint off, longint n);
        return off >= n ? off - n : 0;
    endfunction

    task lex_clear();
        lx_mode   = slt_pkg::M_IDLE;
        lx_block  = 1'b0;
        lx_linec  = 1'b0;
        lx_offset = 0;
        lx_start  = 0;
        lx_len    = 0;
        lx_line   = 1;
        lx_quote  = 8'd0;
        lx_hold[0] = 8'd0;
        lx_hold[1] = 8'd0;
        lx_held   = 0;
    endtask

    task lex_grow(longint n);
        lx_len = (lx_len + n > LEN_LIMIT) ? LEN_LIMIT : lx_len + n;
    endtask

    task lex_begin(longint off, slt_pkg::mode_t m);
        lx_start = off & OFF_LIMIT;
        lx_len   = 1;
        lx_mode  = m;
    endtask

    task lex_record(logic [2:0] k, longint st, longint ln);
        if (step_cnt < 4)
        begin
            step_recs[step_cnt].kind  = k;
            step_recs[step_cnt].start = st[23:0];
            step_recs[step_cnt].len   = ln[15:0];
            step_recs[step_cnt].line  = lx_line[23:0];
            step_recs[step_cnt].last  = 1'b0;
            step_cnt++;
        end
    endtask

    task lex_close(logic [2:0] k);
        lex_record(k, lx_start, lx_len);
        lx_mode = slt_pkg::M_IDLE;
    endtask

    // Handles one byte; n returns how many held bytes must be relexed first.
    task lex_feed(input logic [7:0] c, input longint off, output int n,
                  output logic [7:0] r0, output logic [7:0] r1,
                  output longint o0, output longint o1);
        bit done;
        done = 1'b0;
        n = 0;
        r0 = 8'd0;
        r1 = 8'd0;
        o0 = 0;
        o1 = 0;
        while (!done)
        begin
            case (lx_mode)
                slt_pkg::M_IDLE:
                begin
                    done = 1'b1;
                    if (lx_linec)
                    begin
                        if (c == slt_pkg::CH_LF || c == slt_pkg::CH_CR)
                            lx_linec = 1'b0;
                    end
                    else if (lx_block)
                    begin
                        if (lx_held != 0 && c == slt_pkg::CH_SLASH)
                        begin
                            lx_held = 0;
                            lx_block = 1'b0;
                        end
                        else
                        begin
                            lx_held = 0;
                            if (c == slt_pkg::CH_STAR)
                            begin
                                lx_hold[0] = c;
                                lx_held = 1;
                            end
                        end
                    end
                    else if (cls_ws(c))
                        ;
                    else if (c == slt_pkg::CH_SLASH || c == slt_pkg::CH_STAR)
                    begin
                        lx_hold[0] = c;
                        lx_held = 1;
                        lx_mode = (c == slt_pkg::CH_SLASH) ? slt_pkg::M_SLASH
                                                           : slt_pkg::M_STAR;
                    end
                    else if (c == slt_pkg::CH_DQUOTE || c == slt_pkg::CH_SQUOTE)
                    begin
                        lx_quote = c;
                        lx_start = (off + 1 > OFF_LIMIT) ? OFF_LIMIT : off + 1;
                        lx_len = 0;
                        lx_mode = slt_pkg::M_QUOTE;
                    end
                    else if (cls_letter(c))
                        lex_begin(off, slt_pkg::M_WORD);
                    else if (c == slt_pkg::CH_ZERO)
                        lex_begin(off, slt_pkg::M_ZERO);
                    else if (cls_digit(c))
                        lex_begin(off, slt_pkg::M_INT);
                    else if (cls_op(c))
                        lex_begin(off, slt_pkg::M_OP);
                end
                slt_pkg::M_WORD:
                begin
                    if (cls_letter(c) || cls_digit(c))
                    begin
                        lex_grow(1);
                        done = 1'b1;
                    end
                    else
                        lex_close(slt_pkg::K_WORD);
                end
                slt_pkg::M_ZERO:
                begin
                    if (c == slt_pkg::CH_LX || c == slt_pkg::CH_UX)
                    begin
                        lx_hold[0] = c;
                        lx_held = 1;
                        lx_mode = slt_pkg::M_ZX;
                        done = 1'b1;
                    end
                    else
                        lx_mode = slt_pkg::M_INT;
                end
                slt_pkg::M_INT:
                begin
                    if (cls_digit(c))
                    begin
                        lex_grow(1);
                        done = 1'b1;
                    end
                    else if (c == slt_pkg::CH_DOT)
                    begin
                        lex_grow(1);
                        lx_mode = slt_pkg::M_FRAC;
                        done = 1'b1;
                    end
                    else
                        lex_close(slt_pkg::K_INT);
                end
                slt_pkg::M_ZX:
                begin
                    done = 1'b1;
                    lx_held = 0;
                    if (cls_hex(c))
                    begin
                        lex_grow(2);
                        lx_mode = slt_pkg::M_HEX;
                    end
                    else
                    begin
                        lex_close(slt_pkg::K_INT);
                        r0 = lx_hold[0];
                        o0 = step_back(off, 1);
                        n = 1;
                    end
                end
                slt_pkg::M_HEX:
                begin
                    if (cls_hex(c))
                    begin
                        lex_grow(1);
                        done = 1'b1;
                    end
                    else
                        lex_close(slt_pkg::K_HEX);
                end
                slt_pkg::M_FRAC, slt_pkg::M_EXPD:
                begin
                    if (cls_digit(c))
                    begin
                        lex_grow(1);
                        done = 1'b1;
                    end
                    else if (c == slt_pkg::CH_LF_F)
                    begin
                        lex_grow(1);
                        lex_close(slt_pkg::K_FLOAT);
                        done = 1'b1;
                    end
                    else if (lx_mode == slt_pkg::M_FRAC &&
                             (c == slt_pkg::CH_LE || c == slt_pkg::CH_UE))
                    begin
                        lx_hold[0] = c;
                        lx_held = 1;
                        lx_mode = slt_pkg::M_EXP1;
                        done = 1'b1;
                    end
                    else
                        lex_close(slt_pkg::K_FLOAT);
                end
                slt_pkg::M_EXP1:
                begin
                    done = 1'b1;
                    if (cls_digit(c))
                    begin
                        lex_grow(2);
                        lx_held = 0;
                        lx_mode = slt_pkg::M_EXPD;
                    end
                    else if (c == slt_pkg::CH_PLUS || c == slt_pkg::CH_MINUS)
                    begin
                        lx_hold[1] = c;
                        lx_held = 2;
                        lx_mode = slt_pkg::M_EXP2;
                    end
                    else
                    begin
                        lex_close(slt_pkg::K_FLOAT);
                        r0 = lx_hold[0];
                        o0 = step_back(off, 1);
                        lx_held = 0;
                        n = 1;
                    end
                end
                slt_pkg::M_EXP2:
                begin
                    done = 1'b1;
                    lx_held = 0;
                    if (cls_digit(c))
                    begin
                        lex_grow(3);
                        lx_mode = slt_pkg::M_EXPD;
                    end
                    else
                    begin
                        lex_close(slt_pkg::K_FLOAT);
                        r0 = lx_hold[0];
                        r1 = lx_hold[1];
                        o0 = step_back(off, 2);
                        o1 = step_back(off, 1);
                        n = 2;
                    end
                end
                slt_pkg::M_OP:
                begin
                    if (cls_op(c) && !cls_alone(c))
                    begin
                        lex_grow(1);
                        done = 1'b1;
                    end
                    else
                        lex_close(slt_pkg::K_OP);
                end
                slt_pkg::M_SLASH, slt_pkg::M_STAR:
                begin
                    lx_held = 0;
                    if (c == slt_pkg::CH_SLASH && lx_mode == slt_pkg::M_SLASH)
                    begin
                        lx_linec = 1'b1;
                        lx_mode = slt_pkg::M_IDLE;
                        done = 1'b1;
                    end
                    else if (c == slt_pkg::CH_STAR && lx_mode == slt_pkg::M_SLASH)
                    begin
                        lx_block = 1'b1;
                        lx_mode = slt_pkg::M_IDLE;
                        done = 1'b1;
                    end
                    else if (c == slt_pkg::CH_SLASH && lx_mode == slt_pkg::M_STAR)
                    begin
                        // A stray comment close at token start is dropped.
                        lx_mode = slt_pkg::M_IDLE;
                        done = 1'b1;
                    end
                    else
                        lex_begin(step_back(off, 1), slt_pkg::M_OP);
                end
                slt_pkg::M_QUOTE:
                begin
                    if (c == lx_quote)
                        lex_close(lx_quote == slt_pkg::CH_DQUOTE ? slt_pkg::K_STR
                                                                  : slt_pkg::K_CHAR);
                    else
                        lex_grow(1);
                    done = 1'b1;
                end
                default:
                    lx_mode = slt_pkg::M_IDLE;
            endcase
        end
    endtask

    task lex_flush(longint off);
        case (lx_mode)
            slt_pkg::M_WORD:                  lex_close(slt_pkg::K_WORD);
            slt_pkg::M_ZERO, slt_pkg::M_INT:  lex_close(slt_pkg::K_INT);
            slt_pkg::M_HEX:                   lex_close(slt_pkg::K_HEX);
            slt_pkg::M_FRAC, slt_pkg::M_EXPD: lex_close(slt_pkg::K_FLOAT);
            slt_pkg::M_OP:                    lex_close(slt_pkg::K_OP);
            slt_pkg::M_SLASH, slt_pkg::M_STAR:
            begin
                lx_start = off & OFF_LIMIT;
                lx_len = 1;
                lex_close(slt_pkg::K_OP);
            end
            slt_pkg::M_ZX, slt_pkg::M_EXP1:
            begin
                lex_close(lx_mode == slt_pkg::M_EXP1 ? slt_pkg::K_FLOAT : slt_pkg::K_INT);
                lex_record(slt_pkg::K_WORD, off, 1);
            end
            slt_pkg::M_EXP2:
            begin
                lex_close(slt_pkg::K_FLOAT);
                lex_record(slt_pkg::K_WORD, step_back(off, 1), 1);
                lex_record(slt_pkg::K_OP, off, 1);
            end
            slt_pkg::M_QUOTE:                 lex_close(slt_pkg::K_OPEN);
            default:                          ;
        endcase
    endtask

    task predict_tokens(logic [7:0] c, logic eot);
        longint     off;
        longint     o0;
        longint     o1;
        longint     d0;
        longint     d1;
        logic [7:0] r0;
        logic [7:0] r1;
        logic [7:0] s0;
        logic [7:0] s1;
        int         n;
        int         m;
        step_cnt = 0;
        off = lx_offset;
        lex_feed(c, off, n, r0, r1, o0, o1);
        if (n > 0)
        begin
            lex_feed(r0, o0, m, s0, s1, d0, d1);
            if (n > 1)
                lex_feed(r1, o1, m, s0, s1, d0, d1);
            lex_feed(c, off, m, s0, s1, d0, d1);
        end
        if (lx_offset < OFF_LIMIT)
            lx_offset++;
        if (c == slt_pkg::CH_LF && lx_line < LINE_LIMIT)
            lx_line++;
        if (eot)
        begin
            lex_flush(off);
            lex_clear();
        end
        if (step_cnt > 0)
            step_recs[step_cnt - 1].last = 1'b1;
        for (int i = 0; i < step_cnt; i++)
            expected_tokens = {expected_tokens, step_recs[i]};
    endtask

    // Input side: acceptance bookkeeping and prediction.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            predict_tokens(text_byte, end_of_text);
            bytes_taken++;
        end
    end

    // Output side: record comparison.
    always @(posedge clk)
    begin
        tok_rec_t exp_rec;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_tokens.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected token kind=%0d start=%0d len=%0d",
                             kind, start_offset, lexeme_length);
            end
            else
            begin
                exp_rec = expected_tokens.pop_front();
                if (kind !== exp_rec.kind || start_offset !== exp_rec.start ||
                    lexeme_length !== exp_rec.len || line_number !== exp_rec.line ||
                    last_of_run !== exp_rec.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: token exp k=%0d s=%0d l=%0d ln=%0d lr=%0d",
                                 exp_rec.kind, exp_rec.start, exp_rec.len, exp_rec.line,
                                 exp_rec.last,
                                 " got k=%0d s=%0d l=%0d ln=%0d lr=%0d",
                                 kind, start_offset, lexeme_length,
                                 line_number, last_of_run);
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Byte driver.
    always @(negedge clk)
    begin
        src_item_t it;
        if (rst_n && (!in_valid || bytes_taken == bytes_offered))
        begin
            if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                it = pending_bytes.pop_front();
                text_byte <= it.b;
                end_of_text <= it.eot;
                in_valid <= 1'b1;
                bytes_offered++;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Record receiver, with one long hold-off to back up the block.
    always @(negedge clk)
    begin
        static int  hold_left = 0;
        static bit  hold_done = 1'b0;
        if (!hold_done && bytes_taken >= 120)
        begin
            hold_left = 300;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task add_byte(logic [7:0] b);
        text_buf = {text_buf, b};
    endtask

    task add_str(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(s.len() - 1)];
    endfunction

    task add_run(string s, int lo, int hi);
        repeat ($urandom_range(hi, lo))
            add_byte(pick(s));
    endtask

    task commit_text();
        for (int i = 0; i < text_buf.size(); i++)
            pending_bytes = {pending_bytes,
                             src_item_t'{b: text_buf[i], eot: (i == text_buf.size() - 1)}};
        text_buf.delete();
    endtask

    task add_fragment();
        case ($urandom_range(11))
            0:
            begin
                add_byte(pick("aZq_$x"));
                add_run("abeEfxX_$019", 0, 4);
            end
            1: add_run("0123456789", 1, 4);
            2:
            begin
                add_str($urandom_range(1) ? "0x" : "0X");
                add_run("0123456789abcdefABCDEF", 1, 4);
            end
            3:
            begin
                add_run("0123456789", 1, 2);
                add_str(".");
                add_run("0123456789", 0, 2);
                case ($urandom_range(4))
                    0: add_str("e5");
                    1: add_str($urandom_range(1) ? "E+12" : "e-3");
                    2: add_str("e");
                    3: add_str($urandom_range(1) ? "e+" : "E-");
                    default: ;
                endcase
                if ($urandom_range(2) == 0)
                    add_str("f");
            end
            4:
            begin
                add_byte($urandom_range(1) ? slt_pkg::CH_DQUOTE : slt_pkg::CH_SQUOTE);
                add_run("ab \n/*x'", 0, 4);
                add_byte($urandom_range(1) ? slt_pkg::CH_DQUOTE : slt_pkg::CH_SQUOTE);
            end
            5: add_run("+-*/=><%~!&|^?:{}()[];@,", 1, 4);
            6:
            begin
                add_str("//");
                add_run("a */\"", 0, 3);
                add_byte($urandom_range(1) ? slt_pkg::CH_LF : slt_pkg::CH_CR);
            end
            7:
            begin
                add_str("/*");
                add_run("a*/\n\"", 0, 4);
                add_str("*/");
            end
            8: add_run("\n\t\r ", 1, 2);
            9: add_byte(8'($urandom_range(255)));
            10: add_str($urandom_range(1) ? "0xg" : "*/");
            default: add_str($urandom_range(1) ? "1.e" : "2.E+");
        endcase
        if ($urandom_range(1))
            add_byte(pick(" \n"));
    endtask

    task add_random_texts(int n_bytes);
        int target;
        target = pending_bytes.size() + n_bytes;
        while (pending_bytes.size() < target)
        begin
            repeat ($urandom_range(12, 1))
                add_fragment();
            commit_text();
        end
    endtask

    task wait_drained();
        while (pending_bytes.size() > 0 || in_valid || expected_tokens.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        lex_clear();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed texts, most of which end inside a held decision or an open construct.
        add_str("0x");   commit_text();
        add_str("1.e");  commit_text();
        add_str("2.E-"); commit_text();
        add_str("'ab");  commit_text();
        add_str("/");    commit_text();
        add_str("*");    commit_text();
        add_str("0xF");  commit_text();
        add_str("0xg*/ab"); commit_text();
        add_byte(8'h00);
        add_byte(8'hFF);
        commit_text();
        add_random_texts(55);
        wait_drained();

        send_idle_pct = 71;
        recv_idle_pct = 21;
        add_random_texts(80);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_texts(75);
        wait_drained();
        repeat (20) @(posedge clk);

        if (mismatches == 0 && expected_tokens.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
